>>> hdl/hics_pkg.sv
`default_nettype none
package hics_pkg;
    localparam int MAX_BINS = 256;
    localparam int CNT_W    = $clog2(MAX_BINS + 1);

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_UPPER  = 2'd2;
    localparam logic [1:0] CMD_SAMPLE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_DATA = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;
endpackage
`default_nettype wire

>>> hdl/hics_div.sv
`default_nettype none
// restoring divide, 64/32 with quotient known to fit 32 bits, one bit a cycle
module hics_div import hics_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend_hi,
    input  wire logic [31:0] dividend_lo,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [31:0] div_reg;
    logic [31:0] quo_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        take;

    assign trial = {rem_reg, dvd_reg[31]};
    assign take  = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend_hi;
            dvd_reg <= dividend_lo;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= take ? 32'(trial - {1'b0, div_reg}) : trial[31:0];
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            quo_reg <= {quo_reg[30:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

>>> hdl/histogram_inverse_cdf_sampler.sv
`default_nettype none
// Histogram sampler by inverse transform. Each item carries a command: clear
// the table, append a bin (low edge Q16.16, 24-bit weight), set the upper edge,
// or draw a sample from a Q0.32 uniform fraction; every item gives one result
// (sample Q16.16 and status). Bin edges and running cumulative weights live in
// two synchronous memories of MAX_BINS+1 entries, each with one write port and
// one registered read port; the total weight is also kept in a register. A load
// command goes from acceptance to S_FIN and then back to S_IDLE. A draw passes
// through acceptance, one multiply of fraction by total in S_MUL, a binary
// search that reads one cumulative entry per pass through S_SRD and S_SCMP,
// the states S_F0, S_F1 and S_F2 fetching the chosen bin's edges and cumulative
// bounds, S_DSET loading the divider, a wait in S_DIV on the 32-step bit-serial
// divider until it reports done, a split multiply for the interpolation in
// S_MULA and S_MULB, and S_FIN handing the result to the output register.
// One item is worked at a time; a finished result waits in the output
// register while the next item is accepted, and the block stalls in its last
// state, S_FIN, only while an earlier result is still unread.
module histogram_inverse_cdf_sampler import hics_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_command,
    input  wire logic signed [31:0] s_edge_value,
    input  wire logic [23:0]        s_bin_weight,
    input  wire logic [31:0]        s_uniform_fraction,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_sample_value,
    output logic [1:0]              m_status
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SCMP  = 4'd3;
    localparam logic [3:0] S_F0    = 4'd4;
    localparam logic [3:0] S_F1    = 4'd5;
    localparam logic [3:0] S_F2    = 4'd6;
    localparam logic [3:0] S_DSET  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_MULA  = 4'd9;
    localparam logic [3:0] S_MULB  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [31:0] edge_mem [MAX_BINS+1];
    logic [31:0] cum_mem  [MAX_BINS+1];

    logic [3:0]       state_reg;
    logic [CNT_W-1:0] count_reg;
    logic             upper_reg;
    logic [31:0]      total_reg;
    logic [31:0]      frac_reg;
    logic [63:0]      s_reg;
    logic [CNT_W-1:0] lo_reg, hi_reg;
    logic [CNT_W-1:0] rd_addr;
    logic [31:0]      edge_rd_reg, cum_rd_reg;
    logic             zero_rd_reg;
    logic [31:0]      cum_rd;
    logic [31:0]      c0_reg, c1_reg;
    logic signed [31:0] e0_reg, e1_reg;
    logic             neg_reg;
    logic [32:0]      mag_reg;
    logic [48:0]      phi_reg, plo_reg;
    logic [31:0]      res_val_reg;
    logic [1:0]       res_st_reg;
    logic             m_valid_reg;
    logic [31:0]      m_val_reg;
    logic [1:0]       m_st_reg;

    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid;
    logic [32:0]      sat_sum;
    logic signed [32:0] span;
    logic             div_start, div_done;
    logic [31:0]      quotient;
    logic [49:0]      part_sum;
    logic [31:0]      part;
    logic             accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign sat_sum = {1'b0, total_reg} + {9'd0, s_bin_weight};
    assign cum_rd  = zero_rd_reg ? 32'd0 : cum_rd_reg;
    assign span    = {e1_reg[31], e1_reg} - {e0_reg[31], e0_reg};
    assign part_sum = {1'b0, phi_reg} + {17'd0, plo_reg[48:16]};
    assign part     = part_sum[47:16];
    assign div_start = (state_reg == S_DSET);

    // read address per state
    always_comb begin
        case (state_reg)
            S_SRD:   rd_addr = CNT_W'(mid + 1'b1);
            S_F0:    rd_addr = lo_reg;
            S_F1:    rd_addr = CNT_W'(lo_reg + 1'b1);
            default: rd_addr = lo_reg;
        endcase
    end

    // memories: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (accept && s_command == CMD_APPEND && count_reg != CNT_W'(MAX_BINS)) begin
            edge_mem[count_reg] <= s_edge_value;
            cum_mem[CNT_W'(count_reg + 1'b1)] <= sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
        end else if (accept && s_command == CMD_UPPER) begin
            edge_mem[count_reg] <= s_edge_value;
        end
        edge_rd_reg <= edge_mem[rd_addr];
        cum_rd_reg  <= cum_mem[rd_addr];
        zero_rd_reg <= (rd_addr == '0);
    end

    hics_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .dividend_hi(32'(s_reg[63:32] - c0_reg)),
        .dividend_lo(s_reg[31:0]),
        .divisor    (32'(c1_reg - c0_reg)),
        .done       (div_done),
        .quotient   (quotient)
    );

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            upper_reg   <= 1'b0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_FIN) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        res_val_reg <= '0;
                        case (s_command)
                            CMD_CLEAR: begin
                                count_reg  <= '0;
                                upper_reg  <= 1'b0;
                                total_reg  <= '0;
                                res_st_reg <= ST_OK;
                                state_reg  <= S_FIN;
                            end
                            CMD_APPEND: begin
                                state_reg <= S_FIN;
                                if (count_reg == CNT_W'(MAX_BINS)) begin
                                    res_st_reg <= ST_FULL;
                                end else begin
                                    res_st_reg <= ST_OK;
                                    count_reg <= CNT_W'(count_reg + 1'b1);
                                    upper_reg <= 1'b0;
                                    total_reg <= sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
                                end
                            end
                            CMD_UPPER: begin
                                upper_reg  <= 1'b1;
                                res_st_reg <= ST_OK;
                                state_reg  <= S_FIN;
                            end
                            default: begin
                                if (count_reg == '0 || !upper_reg) begin
                                    res_st_reg <= ST_NO_DATA;
                                    state_reg  <= S_FIN;
                                end else if (total_reg == '0) begin
                                    res_st_reg <= ST_ZERO;
                                    state_reg  <= S_FIN;
                                end else begin
                                    res_st_reg <= ST_OK;
                                    frac_reg  <= s_uniform_fraction;
                                    lo_reg    <= '0;
                                    hi_reg    <= CNT_W'(count_reg - 1'b1);
                                    state_reg <= S_MUL;
                                end
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    s_reg     <= 64'(frac_reg) * 64'(total_reg);
                    state_reg <= (lo_reg < hi_reg) ? S_SRD : S_F0;
                end
                S_SRD: state_reg <= S_SCMP;
                S_SCMP: begin
                    if (cum_rd > s_reg[63:32]) begin
                        hi_reg    <= mid;
                        state_reg <= (lo_reg < mid) ? S_SRD : S_F0;
                    end else begin
                        lo_reg    <= CNT_W'(mid + 1'b1);
                        state_reg <= (CNT_W'(mid + 1'b1) < hi_reg) ? S_SRD : S_F0;
                    end
                end
                S_F0: state_reg <= S_F1;
                S_F1: begin
                    c0_reg    <= cum_rd;
                    e0_reg    <= edge_rd_reg;
                    state_reg <= S_F2;
                end
                S_F2: begin
                    c1_reg    <= cum_rd;
                    e1_reg    <= edge_rd_reg;
                    state_reg <= S_DSET;
                end
                S_DSET: begin
                    neg_reg   <= span[32];
                    mag_reg   <= span[32] ? 33'(-span) : 33'(span);
                    state_reg <= S_DIV;
                end
                S_DIV: if (div_done) state_reg <= S_MULA;
                S_MULA: begin
                    phi_reg   <= 49'(mag_reg) * 49'(quotient[31:16]);
                    plo_reg   <= 49'(mag_reg) * 49'(quotient[15:0]);
                    state_reg <= S_MULB;
                end
                S_MULB: begin
                    res_val_reg <= neg_reg ? 32'(e0_reg - part) : 32'(e0_reg + part);
                    state_reg   <= S_FIN;
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_val_reg   <= res_val_reg;
                        m_st_reg    <= res_st_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_value = m_val_reg;
    assign m_status       = m_st_reg;
endmodule
`default_nettype wire
